[sv/pcg_pkg.sv]
// Shared constants, codes and constant functions of the pixel gamma correction core.
package pcg_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int GAMMA_FRAC_DEF  = 12;

    localparam int LOG_FRAC      = 16;
    localparam int MANT_FRAC     = 31;
    localparam int GAMMA_MAX_INT = 10;
    localparam int CFG_IDX_BITS  = 8;

    localparam int LOG_LAT     = LOG_FRAC + 1;
    localparam int EXP_LAT     = LOG_FRAC;
    localparam int PCG_LATENCY = LOG_LAT + EXP_LAT + 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAMMA    = 8'd0,
        CFG_DATA_MIN = 8'd1,
        CFG_DATA_MAX = 8'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_OFF   = 2'd1,
        SEL_RANGE = 2'd2,
        SEL_POW   = 2'd3
    } t_sel;

    function automatic logic [63:0] pcg_isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q1.31 factor 2^(-2^-k), built by a chain of truncating square roots.
    function automatic logic [31:0] pcg_exp_factor(input int k);
        logic [63:0] c;
        c = pcg_isqrt64(64'd1 << 61);
        for (int j = 1; j < LOG_FRAC; j++) begin
            if (j < k) begin
                c = pcg_isqrt64(c << 31);
            end
        end
        return c[31:0];
    endfunction

endpackage

[sv/pcg_log2.sv]
// Pipelined base-2 logarithm in Q.16, one squaring step per stage.
module pcg_log2
    import pcg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic [SAMPLE_BITS-1:0]                 i_x,
    output logic [$clog2(SAMPLE_BITS)+LOG_FRAC-1:0] o_log
);

    localparam int PW = $clog2(SAMPLE_BITS);

    logic [PW-1:0]       w_p;
    logic [31:0]         r_m    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_frac [0:LOG_FRAC];
    logic [PW-1:0]       r_p    [0:LOG_FRAC];

    always_comb begin
        w_p = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (i_x[i]) begin
                w_p = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0]    <= 32'(i_x) << (6'd31 - 6'(w_p));
        r_frac[0] <= '0;
        r_p[0]    <= w_p;
    end

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
        logic [63:0] w_sq;
        logic [32:0] w_t;
        logic [LOG_FRAC-1:0] w_frac;

        always_comb begin
            w_sq   = r_m[k-1] * r_m[k-1];
            w_t    = w_sq[63:31];
            w_frac = r_frac[k-1];
            w_frac[LOG_FRAC-k] = w_t[32];
        end

        always_ff @(posedge i_clk) begin
            r_m[k]    <= w_t[32] ? w_t[32:1] : w_t[31:0];
            r_frac[k] <= w_frac;
            r_p[k]    <= r_p[k-1];
        end
    end

    assign o_log = {r_p[LOG_FRAC], r_frac[LOG_FRAC]};

endmodule

[sv/pcg_exp2.sv]
// Pipelined 2^(-f) for a Q.16 fraction, one conditional factor per stage.
module pcg_exp2
    import pcg_pkg::*;
(
    input  logic                i_clk,
    input  logic [LOG_FRAC-1:0] i_frac,
    output logic [31:0]         o_mant
);

    logic [31:0]         r_mant [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_f    [0:LOG_FRAC];

    assign r_mant[0] = 32'd1 << MANT_FRAC;
    assign r_f[0]    = i_frac;

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_fac
        localparam logic [31:0] C_K = pcg_exp_factor(k);
        logic [63:0] w_prod;

        always_comb begin
            w_prod = r_mant[k-1] * C_K;
        end

        always_ff @(posedge i_clk) begin
            r_mant[k] <= r_f[k-1][LOG_FRAC-k] ? w_prod[62:31] : r_mant[k-1];
            r_f[k]    <= r_f[k-1];
        end
    end

    assign o_mant = r_mant[LOG_FRAC];

endmodule

[sv/pixel_gamma_correction_core.sv]
// Power-law gamma correction: corrected = range * (offset / range) ^ gamma.
//
// Usage: a sample beat is taken at a rising edge with start high and busy low.
// busy is high only during reset and in the cycle after it, so one sample
// can enter every cycle. Each result appears on o_corrected for one cycle
// with o_valid high, in input order; the receiver cannot stall, so the
// pipeline never holds. The latency is set by two pipelines: the logarithm
// (a normalizing stage, then one squaring multiplier in each of 16 stages,
// 17 stages in all) and the exponential (one factor multiplier in each of
// 16 stages), plus five short stages.
// Throughput is one sample per cycle.
// Configuration beats (gamma, data_min, data_max by index) are taken with
// i_cfg_valid and o_cfg_ready and must be written while no sample is in
// flight. Unknown indexes are ignored. A synchronous low reset empties the
// pipeline and loads gamma 1.0 and the full signed sample range.
module pixel_gamma_correction_core
    import pcg_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int GAMMA_FRAC_BITS = GAMMA_FRAC_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                    o_valid,
    output logic [SAMPLE_BITS-1:0]  o_corrected,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [((SAMPLE_BITS > GAMMA_FRAC_BITS+4) ? SAMPLE_BITS : GAMMA_FRAC_BITS+4)-1:0]
                                    i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int GW = GAMMA_FRAC_BITS + 4;
    localparam int LW = $clog2(SB) + LOG_FRAC;
    localparam int EW = LW + 5;
    localparam int IW = EW - LOG_FRAC;
    localparam logic [GW-1:0] G_ONE   = GW'(1) << GAMMA_FRAC_BITS;
    localparam logic [GW-1:0] G_LIMIT = GW'(GAMMA_MAX_INT) << GAMMA_FRAC_BITS;
    localparam logic [IW-1:0] EI_MAX  = IW'(MANT_FRAC + 2);

    logic                 r_init;
    logic [GW-1:0]        r_gamma;
    logic signed [SB-1:0] r_data_min;
    logic signed [SB-1:0] r_data_max;

    logic [GW-1:0]        w_g;
    logic                 w_rng_ok;
    logic [SB:0]          w_rng_diff;
    logic [SB-1:0]        w_range;
    logic [SB:0]          w_off_diff;
    logic [SB-1:0]        w_off;
    t_sel                 w_sel;
    logic                 w_acc;

    assign busy        = ~r_init;
    assign o_cfg_ready = r_init;
    assign w_acc       = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b0;
            r_gamma    <= G_ONE;
            r_data_min <= {1'b1, {(SB-1){1'b0}}};
            r_data_max <= {1'b0, {(SB-1){1'b1}}};
        end else begin
            r_init <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAMMA:    r_gamma    <= i_cfg_data[GW-1:0];
                    CFG_DATA_MIN: r_data_min <= i_cfg_data[SB-1:0];
                    CFG_DATA_MAX: r_data_max <= i_cfg_data[SB-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Range and clamped gamma follow the registers; the user must hold them while items are in flight (unenforced).
    always_comb begin
        w_g        = (r_gamma > G_LIMIT) ? G_LIMIT : r_gamma;
        w_rng_ok   = r_data_max > r_data_min;
        w_rng_diff = {r_data_max[SB-1], r_data_max} - {r_data_min[SB-1], r_data_min};
        w_range    = w_rng_diff[SB-1:0];
        w_off_diff = {i_sample[SB-1], i_sample} - {r_data_min[SB-1], r_data_min};
        w_off      = (i_sample > r_data_min) ? w_off_diff[SB-1:0] : '0;
        if (!w_rng_ok) begin
            w_sel = SEL_ZERO;
        end else if (w_g == G_ONE) begin
            w_sel = SEL_OFF;
        end else if (w_g == '0) begin
            w_sel = SEL_RANGE;
        end else if (w_off == '0) begin
            w_sel = SEL_ZERO;
        end else if (w_off >= w_range) begin
            w_sel = SEL_RANGE;
        end else begin
            w_sel = SEL_POW;
        end
    end

    // Stage 1: offset and case selection.
    logic          r_s1_valid;
    t_sel          r_s1_sel;
    logic [SB-1:0] r_s1_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
        end
        r_s1_sel <= w_sel;
        r_s1_off <= w_off;
    end

    logic [LW-1:0] w_log_rng;
    logic [LW-1:0] w_log_off;

    pcg_log2 #(.SAMPLE_BITS(SB)) u_log_rng (
        .i_clk (i_clk),
        .i_x   (w_range),
        .o_log (w_log_rng)
    );

    pcg_log2 #(.SAMPLE_BITS(SB)) u_log_off (
        .i_clk (i_clk),
        .i_x   (r_s1_off),
        .o_log (w_log_off)
    );

    // Side data travelling beside the logarithm pipeline.
    logic          r_a_valid [0:LOG_LAT-1];
    t_sel          r_a_sel   [0:LOG_LAT-1];
    logic [SB-1:0] r_a_off   [0:LOG_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOG_LAT; i++) begin
                r_a_valid[i] <= 1'b0;
            end
        end else begin
            r_a_valid[0] <= r_s1_valid;
            for (int i = 1; i < LOG_LAT; i++) begin
                r_a_valid[i] <= r_a_valid[i-1];
            end
        end
        r_a_sel[0] <= r_s1_sel;
        r_a_off[0] <= r_s1_off;
        for (int i = 1; i < LOG_LAT; i++) begin
            r_a_sel[i] <= r_a_sel[i-1];
            r_a_off[i] <= r_a_off[i-1];
        end
    end

    // Log difference.
    logic          r_d_valid;
    t_sel          r_d_sel;
    logic [SB-1:0] r_d_off;
    logic [LW-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_a_valid[LOG_LAT-1];
        end
        r_d_sel <= r_a_sel[LOG_LAT-1];
        r_d_off <= r_a_off[LOG_LAT-1];
        r_d     <= (w_log_rng > w_log_off) ? (w_log_rng - w_log_off) : '0;
    end

    // Exponent e = gamma * d, rounded half up to Q.16.
    logic [LW+GW:0] w_eprod;
    logic           r_e_valid;
    t_sel           r_e_sel;
    logic [SB-1:0]  r_e_off;
    logic [EW-1:0]  r_e;

    assign w_eprod = (LW+GW+1)'(r_d) * (LW+GW+1)'(w_g)
                   + ((LW+GW+1)'(1) << (GAMMA_FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid;
        end
        r_e_sel <= r_d_sel;
        r_e_off <= r_d_off;
        r_e     <= w_eprod[LW+GW:GAMMA_FRAC_BITS];
    end

    logic [31:0] w_mant;

    pcg_exp2 u_exp (
        .i_clk  (i_clk),
        .i_frac (r_e[LOG_FRAC-1:0]),
        .o_mant (w_mant)
    );

    // Side data travelling beside the exponential pipeline.
    logic          r_b_valid [0:EXP_LAT-1];
    t_sel          r_b_sel   [0:EXP_LAT-1];
    logic [SB-1:0] r_b_off   [0:EXP_LAT-1];
    logic [IW-1:0] r_b_ei    [0:EXP_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < EXP_LAT; i++) begin
                r_b_valid[i] <= 1'b0;
            end
        end else begin
            r_b_valid[0] <= r_e_valid;
            for (int i = 1; i < EXP_LAT; i++) begin
                r_b_valid[i] <= r_b_valid[i-1];
            end
        end
        r_b_sel[0] <= r_e_sel;
        r_b_off[0] <= r_e_off;
        r_b_ei[0]  <= r_e[EW-1:LOG_FRAC];
        for (int i = 1; i < EXP_LAT; i++) begin
            r_b_sel[i] <= r_b_sel[i-1];
            r_b_off[i] <= r_b_off[i-1];
            r_b_ei[i]  <= r_b_ei[i-1];
        end
    end

    // Scale the range by the mantissa.
    logic          r_p_valid;
    t_sel          r_p_sel;
    logic [SB-1:0] r_p_off;
    logic          r_p_big;
    logic [5:0]    r_p_shift;
    logic [63:0]   r_p_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_b_valid[EXP_LAT-1];
        end
        r_p_sel   <= r_b_sel[EXP_LAT-1];
        r_p_off   <= r_b_off[EXP_LAT-1];
        r_p_big   <= r_b_ei[EXP_LAT-1] >= EI_MAX;
        r_p_shift <= 6'(r_b_ei[EXP_LAT-1][5:0]) + 6'(MANT_FRAC);
        r_p_prod  <= 64'(w_range) * 64'(w_mant);
    end

    // Round, select the case and saturate to the range.
    logic [64:0]   w_rnd;
    logic [64:0]   w_q;
    logic [SB-1:0] w_res;

    always_comb begin
        w_rnd = {1'b0, r_p_prod} + (65'd1 << (r_p_shift - 6'd1));
        w_q   = w_rnd >> r_p_shift;
        case (r_p_sel)
            SEL_ZERO:  w_res = '0;
            SEL_OFF:   w_res = (r_p_off > w_range) ? w_range : r_p_off;
            SEL_RANGE: w_res = w_range;
            SEL_POW: begin
                if (r_p_big) begin
                    w_res = '0;
                end else if (w_q > 65'(w_range)) begin
                    w_res = w_range;
                end else begin
                    w_res = w_q[SB-1:0];
                end
            end
            default:   w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_p_valid;
        end
        o_corrected <= w_res;
    end

endmodule

[sv/pcg_checker.sv]
// Port-level checks of the pixel gamma correction core and their bind.
module pcg_checker
    import pcg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic [SAMPLE_BITS-1:0] o_corrected
);

    // Every accepted sample beat yields a result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PCG_LATENCY o_valid)
        else $error("result beat missing after accepted sample");

    // No result beat appears without a sample accepted one latency earlier.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PCG_LATENCY))
        else $error("result beat without matching sample");

    // Reset empties the pipeline and blocks input in the cycle after it.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && busy))
        else $error("pipeline not cleared by reset");

    // Every result beat carries defined bits, also the zero results with no range.
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_corrected))
        else $error("result beat carries unknown bits");

endmodule

bind pixel_gamma_correction_core pcg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pcg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_corrected (o_corrected)
);

[tb/tb_top.sv]
// Self-checking testbench for the pixel gamma correction core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pcg_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 8'd3;
    localparam int SETTLE_CYCLES = PCG_LATENCY + 8;
    localparam longint CYCLE_LIMIT = 400000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [15:0]      i_sample;
    logic                    o_valid;
    logic [15:0]             o_corrected;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [15:0]             i_cfg_data;

    pixel_gamma_correction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sample(i_sample), .o_valid(o_valid), .o_corrected(o_corrected),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [15:0]        gamma_q412;
    logic signed [15:0] frame_min;
    logic signed [15:0] frame_max;

    logic signed [15:0] samples_to_send[$];
    logic [15:0]        corrected_due[$];
    int                 errors;
    int                 samples_sent;
    int                 results_seen;
    longint             cycles;
    int                 burst_left;
    int                 gap_left;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] one;
        rem  = val;
        root = 0;
        one  = 64'd1 << 62;
        while (one > rem)
            one = one >> 2;
        while (one != 0) begin
            if (rem >= root + one) begin
                rem  = rem - (root + one);
                root = (root >> 1) + one;
            end else begin
                root = root >> 1;
            end
            one = one >> 2;
        end
        return root;
    endfunction

    // Base-2 logarithm in Q.16: leading-one position plus 16 squaring steps.
    function automatic logic [63:0] log2_q16(input logic [63:0] x);
        int          lead;
        logic [63:0] m;
        logic [63:0] frac;
        lead = 0;
        frac = 0;
        while (lead < 63 && (x >> (lead + 1)) != 0)
            lead++;
        m = (lead <= 31) ? (x << (31 - lead)) : (x >> (lead - 31));
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(lead) << 16) | frac;
    endfunction

    // range * 2^(-e) with e in Q.16, rounded half up.
    function automatic logic [63:0] attenuate(input logic [63:0] range, input logic [63:0] e);
        logic [63:0] ei;
        logic [63:0] f;
        logic [63:0] mant;
        logic [63:0] factor;
        logic [63:0] sh;
        ei     = e >> 16;
        f      = e & 64'hFFFF;
        mant   = 64'd1 << 31;
        factor = int_sqrt(64'd1 << 61);
        for (int k = 1; k <= 16; k++) begin
            if (f[16 - k])
                mant = (mant * factor) >> 31;
            factor = int_sqrt(factor << 31);
        end
        if (ei >= 33)
            return 0;
        sh = 31 + ei;
        return (range * mant + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [15:0] gamma_correct(input logic signed [15:0] s);
        logic [63:0] g;
        logic [63:0] range;
        logic [63:0] off;
        logic [63:0] res;
        logic [63:0] lr;
        logic [63:0] lo;
        logic [63:0] d;
        g = 64'(gamma_q412);
        if (g > 64'd40960)
            g = 64'd40960;
        if (frame_max <= frame_min)
            return 16'd0;
        range = 64'(int'(frame_max) - int'(frame_min));
        off   = (s > frame_min) ? 64'(int'(s) - int'(frame_min)) : 64'd0;
        if (g == 64'd4096) begin
            res = off;
        end else if (g == 0) begin
            res = range;
        end else if (off == 0) begin
            res = 0;
        end else if (off >= range) begin
            res = range;
        end else begin
            lr  = log2_q16(range);
            lo  = log2_q16(off);
            d   = (lr > lo) ? lr - lo : 64'd0;
            res = attenuate(range, (d * g + 64'd2048) >> 12);
        end
        if (res > range)
            res = range;
        return res[15:0];
    endfunction

    // Sample driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_sample   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (start && !busy) begin
                corrected_due.push_back(gamma_correct(i_sample));
                samples_sent++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (samples_to_send.size() > 0) begin
                start    <= 1'b1;
                i_sample <= samples_to_send.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (corrected_due.size() == 0) begin
                $display("%0t: unexpected result beat, actual corrected=%0d", $time, o_corrected);
                errors++;
            end else begin
                if (o_corrected !== corrected_due[0]) begin
                    $display("%0t: corrected mismatch, expected %0d, actual %0d",
                             $time, corrected_due[0], o_corrected);
                    errors++;
                end
                void'(corrected_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, corrected_due.size());
            $display("[pixel_gamma_correction_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GAMMA:    gamma_q412 = val;
            CFG_DATA_MIN: frame_min  = val;
            CFG_DATA_MAX: frame_max  = val;
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [15:0] g, input int lo, input int hi);
        write_reg(CFG_GAMMA, g);
        write_reg(CFG_DATA_MIN, 16'(lo));
        write_reg(CFG_DATA_MAX, 16'(hi));
    endtask

    // Mostly samples near the configured window, some anywhere.
    task automatic queue_random(input int count);
        int lo;
        int hi;
        lo = (frame_min < frame_max) ? int'(frame_min) : int'(frame_max);
        hi = (frame_min < frame_max) ? int'(frame_max) : int'(frame_min);
        lo = (lo - 3 < -32768) ? -32768 : lo - 3;
        hi = (hi + 3 > 32767) ? 32767 : hi + 3;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0)
                samples_to_send.push_back(16'($urandom));
            else
                samples_to_send.push_back(16'(lo + int'($urandom_range(0, hi - lo))));
        end
    endtask

    // Hold the test sequence until every sample is sent, every result is back and the pipeline is empty.
    task automatic drain();
        while (samples_to_send.size() > 0 || corrected_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int lo;
        int hi;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        start        = 1'b0;
        i_sample     = '0;
        errors       = 0;
        samples_sent = 0;
        results_seen = 0;
        cycles       = 0;
        gamma_q412   = 16'd4096;
        frame_min    = -16'sd32768;
        frame_max    = 16'sd32767;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: identity over the full signed range.
        samples_to_send = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sh5555, -16'sh5556};
        drain();

        set_frame(16'h2000, 0, 1000);
        samples_to_send = '{-16'sd5, 16'sd0, 16'sd1, 16'sd500, 16'sd999, 16'sd1000,
                            16'sd1001, 16'sd32767, -16'sd32768};
        queue_random(40);
        drain();
        set_frame(16'h0000, -100, 100);
        samples_to_send = '{-16'sd100, -16'sd101, 16'sd0};
        queue_random(40);
        drain();
        // Gamma above the limit clamps to ten; offset one gives a huge exponent.
        set_frame(16'hFFFF, -32768, 32767);
        samples_to_send = '{-16'sd32767, 16'sd0, 16'sd32766};
        queue_random(40);
        drain();
        set_frame(16'h0800, 10, 10);
        samples_to_send = '{16'sd10, 16'sd11, 16'sd9};
        queue_random(30);
        drain();
        set_frame(16'h3000, 50, -50);
        samples_to_send = '{16'sd0, 16'sd50};
        queue_random(30);
        drain();
        set_frame(16'd40960, 0, 1);
        queue_random(30);
        drain();
        write_reg(CFG_UNUSED, 16'h1234);
        set_frame(16'h0001, -1000, 30000);
        queue_random(40);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                              : lo + int'($urandom_range(1, 600));
            if (hi > 32767)
                hi = 32767;
            set_frame(($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 40960)), lo, hi);
            queue_random(50);
            drain();
        end

        $display("Run covered %0d samples and %0d results over 16 configuration phases,",
                 samples_sent, results_seen);
        $display("including zero, inverted, tiny and full ranges and gamma from 0 to the clamp.");
        if (errors == 0) begin
            $display("[pixel_gamma_correction_core] OK");
        end else begin
            $display("[pixel_gamma_correction_core] ERROR");
        end
        $finish;
    end

endmodule
